@@ rtl/mnva_pkg.sv @@
`timescale 1ns / 1ps
// mnva_pkg: item types, message codes and controller/datapath interface structs
// for the midi note voice allocator; no dependencies
package mnva_pkg;

	// midi message kinds, upper nibble of a status byte
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_SYSTEM   = 4'hF;

	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;

	// result kinds
	localparam logic KIND_VOICE = 1'b0;
	localparam logic KIND_SLEEP = 1'b1;

	// input item commands
	localparam logic CMD_SERIAL = 1'b0;
	localparam logic CMD_USB    = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] first_byte;
		logic [6:0] second_byte;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] voice;
		logic [6:0] pitch;
		logic       silent;
		logic       last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_usb;
		logic hold_status;
		logic hold_note;
		logic load_held;
		logic note_on;
		logic off_start;
		logic off_emit;
		logic sleep_emit;
	} mnva_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic byte_is_status;
		logic byte_is_system;
		logic byte_is_sysex_start;
		logic byte_is_sysex_end;
		logic msg_is_off;
		logic on_hit;
		logic pending_any;
		logic pending_one;
		logic remaining;
	} mnva_sts_t;

endpackage

@@ rtl/midi_note_voice_allocator_top.sv @@
`timescale 1ns / 1ps
// midi note voice allocator: serial or usb midi in, voice assignments and sleep out.
// one item at a time: a serial byte that does not complete a message is taken in idle alone,
// a note-on or an ignored message also passes decode, where a note-on result is registered;
// a note-off passes decode and off, with one result per voice that held the note, then a
// sleep result when no voice is left playing; a result held by result_ready stalls the sequence.
// arst_n clears the parser, the voice table (all idle, voice i at age i) and valids.
module midi_note_voice_allocator_top import mnva_pkg::*; #(
	parameter int VOICES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	mnva_cmd_t cmd;
	mnva_sts_t sts;

	mnva_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_command (item.command),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	mnva_datapath #(
		.VOICES (VOICES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

@@ rtl/mnva_datapath.sv @@
`timescale 1ns / 1ps
// mnva_datapath: message registers, voice table (pitch, idle, age) and result register
// depends on mnva_pkg; driven by mnva_ctrl commands
module mnva_datapath import mnva_pkg::*; #(
	parameter int VOICES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  mnva_cmd_t cmd,
	output mnva_sts_t sts,
	output out_item_t result
);

	localparam int VW = $clog2(VOICES);

	logic [7:0] held_status_q;
	logic [6:0] held_note_q;
	logic [7:0] msg_status_q;
	logic [6:0] msg_note_q;

	logic [VOICES-1:0] voice_idle_q;
	logic [6:0]        voice_pitch_q [VOICES];
	logic [VW-1:0]     voice_age_q [VOICES];
	logic [VOICES-1:0] pending_q;
	logic              remaining_q;
	out_item_t         result_q;

	logic [VOICES-1:0] match;
	logic [3:0]        chan;
	logic [4:0]        chan_ext;
	logic              on_hit;
	logic [VW-1:0]     on_voice;
	logic [VW-1:0]     idle_idx;
	logic [VW-1:0]     old_idx;
	logic              old_found;
	logic [VOICES-1:0] low_bit;
	logic [VOICES-1:0] pending_rest;
	logic [VW-1:0]     low_idx;
	logic [VW-1:0]     on_old_age;

	function automatic logic [1:0] voice_field(input logic [VW-1:0] v);
		logic [3:0] w;
		w = 4'(v);
		return w[1:0];
	endfunction

	assign chan     = msg_status_q[3:0];
	assign chan_ext = {1'b0, chan};

	always_comb begin
		for (int i = 0; i < VOICES; i++) begin
			match[i] = !voice_idle_q[i] && (voice_pitch_q[i] == msg_note_q);
		end
	end

	// voice search for note-on; descending loops leave the lowest index
	always_comb begin
		idle_idx  = '0;
		old_idx   = '0;
		old_found = 1'b0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (voice_idle_q[i]) begin
				idle_idx = VW'(i);
			end
			if (voice_age_q[i] == VW'(VOICES - 1)) begin
				old_idx   = VW'(i);
				old_found = 1'b1;
			end
		end
		if (chan != 4'd0) begin
			on_hit   = chan_ext <= 5'(VOICES);
			on_voice = VW'(chan_ext - 5'd1);
		end else begin
			on_hit = !(|match);
			if (|voice_idle_q) begin
				on_voice = idle_idx;
			end else if (old_found) begin
				on_voice = old_idx;
			end else begin
				on_voice = '0;
			end
		end
	end

	assign on_old_age = voice_age_q[on_voice];

	// lowest pending note-off voice
	assign low_bit      = pending_q & (~pending_q + VOICES'(1));
	assign pending_rest = pending_q & ~low_bit;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < VOICES; i++) begin
			if (low_bit[i]) begin
				low_idx = VW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_status_q <= '0;
			held_note_q   <= '0;
			voice_idle_q  <= '1;
			pending_q     <= '0;
			remaining_q   <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				voice_age_q[i] <= VW'(i);
			end
		end else begin
			if (cmd.hold_status) begin
				held_status_q <= item.first_byte;
			end
			if (cmd.hold_note) begin
				held_note_q <= item.first_byte[6:0];
			end
			if (cmd.note_on) begin
				voice_idle_q[on_voice] <= 1'b0;
				for (int j = 0; j < VOICES; j++) begin
					if (VW'(j) == on_voice) begin
						voice_age_q[j] <= '0;
					end else if (voice_age_q[j] < on_old_age) begin
						voice_age_q[j] <= voice_age_q[j] + VW'(1);
					end
				end
			end
			if (cmd.off_start) begin
				pending_q    <= match;
				voice_idle_q <= voice_idle_q | match;
				remaining_q  <= |(~voice_idle_q & ~match);
			end
			if (cmd.off_emit) begin
				pending_q <= pending_rest;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_usb) begin
			msg_status_q <= item.first_byte;
			msg_note_q   <= item.second_byte;
		end else if (cmd.load_held) begin
			msg_status_q <= held_status_q;
			msg_note_q   <= held_note_q;
		end
		if (cmd.note_on) begin
			voice_pitch_q[on_voice] <= msg_note_q;
			result_q.kind   <= KIND_VOICE;
			result_q.voice  <= voice_field(on_voice);
			result_q.pitch  <= msg_note_q;
			result_q.silent <= msg_note_q == 7'd0;
			result_q.last   <= 1'b1;
		end else if (cmd.off_emit) begin
			result_q.kind   <= KIND_VOICE;
			result_q.voice  <= voice_field(low_idx);
			result_q.pitch  <= 7'd0;
			result_q.silent <= 1'b1;
			result_q.last   <= (pending_rest == '0) && remaining_q;
		end else if (cmd.sleep_emit) begin
			result_q.kind   <= KIND_SLEEP;
			result_q.voice  <= 2'd0;
			result_q.pitch  <= 7'd0;
			result_q.silent <= 1'b0;
			result_q.last   <= 1'b1;
		end
	end

	assign result = result_q;

	assign sts.byte_is_status      = item.first_byte[7];
	assign sts.byte_is_system      = item.first_byte[7:4] == MSG_SYSTEM;
	assign sts.byte_is_sysex_start = item.first_byte == SYSEX_START;
	assign sts.byte_is_sysex_end   = item.first_byte == SYSEX_END;
	assign sts.msg_is_off          = msg_status_q[7:4] == MSG_NOTE_OFF;
	assign sts.on_hit              = (msg_status_q[7:4] == MSG_NOTE_ON) && on_hit;
	assign sts.pending_any         = |pending_q;
	assign sts.pending_one         = (pending_q != '0) && (pending_rest == '0);
	assign sts.remaining           = remaining_q;

endmodule

@@ rtl/mnva_ctrl.sv @@
`timescale 1ns / 1ps
// mnva_ctrl: handshake, serial parser phase and message sequencing state machine
// depends on mnva_pkg; commands mnva_datapath
module mnva_ctrl import mnva_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  logic      item_command,
	output logic      result_valid,
	input  logic      result_ready,
	input  mnva_sts_t sts,
	output mnva_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_OFF    = 3'd2;
	localparam logic [2:0] ST_SLEEP  = 3'd3;

	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_DATA1 = 2'd1;
	localparam logic [1:0] PH_DATA2 = 2'd2;
	localparam logic [1:0] PH_SYSEX = 2'd3;

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;
	logic       emit;

	assign item_ready   = state_q == ST_IDLE;
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign slot_free    = !out_valid_q || result_ready;
	assign emit         = cmd.note_on || cmd.off_emit || cmd.sleep_emit;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item_command == CMD_USB) begin
						cmd.load_usb = 1'b1;
						state_d      = ST_DECODE;
					end else if (sts.byte_is_status) begin
						if (sts.byte_is_system) begin
							if (sts.byte_is_sysex_start) begin
								phase_d = PH_SYSEX;
							end else if (sts.byte_is_sysex_end) begin
								phase_d = PH_WAIT;
							end
						end else begin
							phase_d         = PH_DATA1;
							cmd.hold_status = 1'b1;
						end
					end else if (phase_q == PH_DATA1) begin
						cmd.hold_note = 1'b1;
						phase_d       = PH_DATA2;
					end else if (phase_q == PH_DATA2) begin
						cmd.load_held = 1'b1;
						phase_d       = PH_WAIT;
						state_d       = ST_DECODE;
					end
				end
			end
			ST_DECODE: begin
				if (sts.msg_is_off) begin
					cmd.off_start = 1'b1;
					state_d       = ST_OFF;
				end else if (sts.on_hit) begin
					if (slot_free) begin
						cmd.note_on = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OFF: begin
				if (sts.pending_any) begin
					if (slot_free) begin
						cmd.off_emit = 1'b1;
						if (sts.pending_one) begin
							state_d = sts.remaining ? ST_IDLE : ST_SLEEP;
						end
					end
				end else begin
					state_d = sts.remaining ? ST_IDLE : ST_SLEEP;
				end
			end
			ST_SLEEP: begin
				if (slot_free) begin
					cmd.sleep_emit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("result register overwritten while stalled");

	// at most one result per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.note_on, cmd.off_emit, cmd.sleep_emit}))
		else $error("more than one result source in a cycle");

	// sleep only when nothing is left playing
	a_sleep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SLEEP |-> !sts.remaining)
		else $error("sleep while a voice still plays");

	// a note-off scan, started only from decode, is always entered
	a_off_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.off_start |=> state_q == ST_OFF)
		else $error("note-off scan not entered");
`endif

endmodule
